### src/idq_pkg.sv
// Shared types and constants for the integer deque with value delete.
`default_nettype none

package idq_pkg;

  localparam int unsigned CAPACITY_DEF = 32;
  localparam int unsigned MAX_RESULTS  = 32;
  localparam int unsigned DATA_W       = 32;

  typedef enum logic [3:0] {
    OP_PUSH_FRONT = 4'd0,
    OP_PUSH_BACK  = 4'd1,
    OP_POP_FRONT  = 4'd2,
    OP_POP_BACK   = 4'd3,
    OP_DELETE     = 4'd4,
    OP_CLEAR      = 4'd5,
    OP_EMIT_ALL   = 4'd6,
    OP_EMIT_FIRST = 4'd7,
    OP_EMIT_LAST  = 4'd8
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [3:0]               opcode;
    logic signed [DATA_W-1:0] operand;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [1:0]               status;
    logic                     last;
  } res_t;

endpackage

`default_nettype wire

### src/idq_store.sv
// Ring-addressed entry memory with registered read.
`default_nettype none

module idq_store #(
  parameter int unsigned CAPACITY = idq_pkg::CAPACITY_DEF,
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1)
) (
  input  wire logic                             clk_i,
  input  wire logic [IDX_W-1:0]                 rd_base_i,
  input  wire logic                             rd_en_i,
  input  wire logic [CNT_W-1:0]                 rd_off_i,
  output      logic signed [idq_pkg::DATA_W-1:0] rd_data_o,
  input  wire logic                             wr_en_i,
  input  wire logic [IDX_W-1:0]                 wr_base_i,
  input  wire logic [CNT_W-1:0]                 wr_off_i,
  input  wire logic signed [idq_pkg::DATA_W-1:0] wr_data_i
);

  localparam int unsigned SUM_W = CNT_W + 1;

  logic signed [idq_pkg::DATA_W-1:0] mem [CAPACITY];
  logic [SUM_W-1:0] rd_sum, wr_sum;
  logic [IDX_W-1:0] rd_slot, wr_slot;

  always_comb begin
    rd_sum = SUM_W'(rd_base_i) + SUM_W'(rd_off_i);
    wr_sum = SUM_W'(wr_base_i) + SUM_W'(wr_off_i);
    if (rd_sum >= SUM_W'(CAPACITY)) begin
      rd_sum = rd_sum - SUM_W'(CAPACITY);
    end
    if (wr_sum >= SUM_W'(CAPACITY)) begin
      wr_sum = wr_sum - SUM_W'(CAPACITY);
    end
    rd_slot = rd_sum[IDX_W-1:0];
    wr_slot = wr_sum[IDX_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_slot] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_slot];
    end
  end

endmodule

`default_nettype wire

### src/integer_deque_with_value_delete.sv
// Top level of the integer deque with value delete.
//
//   channel   ports                       handshake
//   command   start, busy, req_i          taken when start & !busy
//   result    res_valid_o, res_o          each word shown for exactly one cycle, never stalled
//
// Push, clear and unused opcodes are handled in the accept cycle; the status word follows in the next cycle.
// Pop goes through S_POP, which registers the word from the registered read of the entry memory.
// Delete walks the fill, one entry a cycle through the memory port.
// Emit streams one word a cycle once the first read is registered, at most MAX_RESULTS words.
// Reset clears front index and fill; memory contents need no clearing.
`default_nettype none

module integer_deque_with_value_delete #(
  parameter int unsigned CAPACITY = idq_pkg::CAPACITY_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start,
  output      logic         busy,
  input  wire idq_pkg::req_t req_i,
  output      logic         res_valid_o,
  output      idq_pkg::res_t res_o
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_EMIT,
    S_DEL
  } state_e;

  state_e state_q;
  logic [IDX_W-1:0] front_q;
  logic [CNT_W-1:0] fill_q;
  logic [CNT_W-1:0] left_q;
  logic [CNT_W-1:0] rd_off_q;
  logic [CNT_W-1:0] kept_q;
  logic signed [idq_pkg::DATA_W-1:0] operand_q;
  logic         res_valid_q;
  idq_pkg::res_t res_q;

  logic accept;
  logic full, empty;
  logic [IDX_W-1:0] front_dec, front_inc;
  logic [CNT_W-1:0] cnt_n, cnt_emit, first_off;
  logic             emit_op;
  logic [CNT_W-1:0] kept_d;
  logic             match;

  logic                              rd_en;
  logic [CNT_W-1:0]                  rd_off;
  logic signed [idq_pkg::DATA_W-1:0] rd_data;
  logic                              wr_en;
  logic [IDX_W-1:0]                  wr_base;
  logic [CNT_W-1:0]                  wr_off;
  logic signed [idq_pkg::DATA_W-1:0] wr_data;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign full   = (fill_q == CNT_W'(CAPACITY));
  assign empty  = (fill_q == '0);

  assign front_dec = (front_q == '0) ? IDX_W'(CAPACITY - 1) : front_q - IDX_W'(1);
  assign front_inc = (front_q == IDX_W'(CAPACITY - 1)) ? '0 : front_q + IDX_W'(1);

  assign match  = (rd_data == operand_q);
  assign kept_d = match ? kept_q : kept_q + CNT_W'(1);

  always_comb begin
    emit_op = 1'b0;
    cnt_n   = fill_q;
    case (req_i.opcode) inside
      idq_pkg::OP_EMIT_ALL: begin
        emit_op = 1'b1;
        cnt_n   = fill_q;
      end
      idq_pkg::OP_EMIT_FIRST, idq_pkg::OP_EMIT_LAST: begin
        emit_op = 1'b1;
        if (req_i.operand[idq_pkg::DATA_W-1]) begin
          cnt_n = '0;
        end else if (req_i.operand > $signed({1'b0, (idq_pkg::DATA_W-1)'(fill_q)})) begin
          cnt_n = fill_q;
        end else begin
          cnt_n = req_i.operand[CNT_W-1:0];
        end
      end
      default: begin
        emit_op = 1'b0;
      end
    endcase
    first_off = (req_i.opcode == idq_pkg::OP_EMIT_LAST) ? fill_q - cnt_n : '0;
    cnt_emit  = cnt_n;
    if ((CAPACITY > idq_pkg::MAX_RESULTS) &&
        (32'(cnt_n) > 32'(idq_pkg::MAX_RESULTS))) begin
      cnt_emit = CNT_W'(idq_pkg::MAX_RESULTS);
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_off  = rd_off_q;
    wr_en   = 1'b0;
    wr_base = front_q;
    wr_off  = kept_q;
    wr_data = rd_data;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_i.opcode)
            idq_pkg::OP_PUSH_FRONT: begin
              wr_en   = !full;
              wr_base = front_dec;
              wr_off  = '0;
              wr_data = req_i.operand;
            end
            idq_pkg::OP_PUSH_BACK: begin
              wr_en   = !full;
              wr_off  = fill_q;
              wr_data = req_i.operand;
            end
            idq_pkg::OP_POP_FRONT: begin
              rd_en  = !empty;
              rd_off = '0;
            end
            idq_pkg::OP_POP_BACK: begin
              rd_en  = !empty;
              rd_off = fill_q - CNT_W'(1);
            end
            idq_pkg::OP_DELETE: begin
              rd_en  = !empty;
              rd_off = '0;
            end
            default: begin
              rd_en  = emit_op && !empty && (cnt_emit != '0);
              rd_off = first_off;
            end
          endcase
        end
      end
      S_EMIT: begin
        rd_en = (left_q > CNT_W'(1));
      end
      S_DEL: begin
        rd_en = (left_q > CNT_W'(1));
        wr_en = !match;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  idq_store #(
    .CAPACITY (CAPACITY)
  ) u_store (
    .clk_i     (clk_i),
    .rd_base_i (front_q),
    .rd_en_i   (rd_en),
    .rd_off_i  (rd_off),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_base_i (wr_base),
    .wr_off_i  (wr_off),
    .wr_data_i (wr_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      fill_q      <= '0;
      left_q      <= '0;
      rd_off_q    <= '0;
      kept_q      <= '0;
      operand_q   <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            res_q.data   <= '0;
            res_q.status <= idq_pkg::ST_OK;
            res_q.last   <= 1'b1;
            operand_q    <= req_i.operand;
            case (req_i.opcode)
              idq_pkg::OP_PUSH_FRONT, idq_pkg::OP_PUSH_BACK: begin
                res_valid_q <= 1'b1;
                if (full) begin
                  res_q.status <= idq_pkg::ST_FULL;
                end else begin
                  fill_q <= fill_q + CNT_W'(1);
                  if (req_i.opcode == idq_pkg::OP_PUSH_FRONT) begin
                    front_q <= front_dec;
                  end
                end
              end
              idq_pkg::OP_POP_FRONT, idq_pkg::OP_POP_BACK: begin
                if (empty) begin
                  res_valid_q  <= 1'b1;
                  res_q.status <= idq_pkg::ST_EMPTY;
                end else begin
                  state_q <= S_POP;
                  fill_q  <= fill_q - CNT_W'(1);
                  if (req_i.opcode == idq_pkg::OP_POP_FRONT) begin
                    front_q <= front_inc;
                  end
                end
              end
              idq_pkg::OP_DELETE: begin
                if (empty) begin
                  res_valid_q <= 1'b1;
                end else begin
                  state_q  <= S_DEL;
                  left_q   <= fill_q;
                  rd_off_q <= CNT_W'(1);
                  kept_q   <= '0;
                end
              end
              idq_pkg::OP_CLEAR: begin
                res_valid_q <= 1'b1;
                fill_q      <= '0;
                front_q     <= '0;
              end
              default: begin
                if (emit_op && empty) begin
                  res_valid_q  <= 1'b1;
                  res_q.status <= idq_pkg::ST_EMPTY;
                end else if (emit_op && (cnt_emit != '0)) begin
                  state_q  <= S_EMIT;
                  left_q   <= cnt_emit;
                  rd_off_q <= first_off + CNT_W'(1);
                end else begin
                  res_valid_q <= 1'b1;
                end
              end
            endcase
          end
        end
        S_POP: begin
          res_valid_q  <= 1'b1;
          res_q.data   <= rd_data;
          res_q.status <= idq_pkg::ST_OK;
          res_q.last   <= 1'b1;
          state_q      <= S_IDLE;
        end
        S_EMIT: begin
          res_valid_q  <= 1'b1;
          res_q.data   <= rd_data;
          res_q.status <= idq_pkg::ST_OK;
          res_q.last   <= (left_q == CNT_W'(1));
          left_q       <= left_q - CNT_W'(1);
          rd_off_q     <= rd_off_q + CNT_W'(1);
          if (left_q == CNT_W'(1)) begin
            state_q <= S_IDLE;
          end
        end
        S_DEL: begin
          kept_q   <= kept_d;
          left_q   <= left_q - CNT_W'(1);
          rd_off_q <= rd_off_q + CNT_W'(1);
          if (left_q == CNT_W'(1)) begin
            fill_q       <= kept_d;
            res_valid_q  <= 1'b1;
            res_q.data   <= '0;
            res_q.status <= idq_pkg::ST_OK;
            res_q.last   <= 1'b1;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

### verif/testbench.sv
// Self-checking testbench: drives deque commands and checks every result word against a mirror.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CAP          = idq_pkg::CAPACITY_DEF;
  localparam int unsigned ITEMS_TARGET = 170;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam logic [3:0]  OP_UNUSED_LO = 4'd9;
  localparam logic [3:0]  OP_UNUSED_HI = 4'd15;

  class deque_mirror;
    logic [31:0] slot [CAP];
    int unsigned head;
    int unsigned fill;
    idq_pkg::res_t awaited [$];
    int unsigned errors;
    int unsigned words_taken;
    int unsigned results_seen;
    int unsigned full_hits;
    int unsigned empty_hits;
    int unsigned peak_fill;

    function new();
      head = 0;
      fill = 0;
      errors = 0;
      words_taken = 0;
      results_seen = 0;
      full_hits = 0;
      empty_hits = 0;
      peak_fill = 0;
    endfunction

    function void await_word(logic [31:0] d, idq_pkg::status_e st, bit lst);
      idq_pkg::res_t r;
      r.data   = d;
      r.status = st;
      r.last   = lst;
      awaited.push_back(r);
      if (st == idq_pkg::ST_FULL) full_hits++;
      if (st == idq_pkg::ST_EMPTY) empty_hits++;
    endfunction

    function int unsigned clamp_count(logic [31:0] raw);
      if (raw[31]) return 0;
      return (raw > fill) ? fill : int'(raw);
    endfunction

    function void emit_span(int unsigned first, int unsigned count);
      if (fill == 0) begin
        await_word('0, idq_pkg::ST_EMPTY, 1'b1);
        return;
      end
      if (count == 0) begin
        await_word('0, idq_pkg::ST_OK, 1'b1);
        return;
      end
      if (count > idq_pkg::MAX_RESULTS) count = idq_pkg::MAX_RESULTS;
      for (int unsigned i = 0; i < count; i++)
        await_word(slot[(head + first + i) % CAP], idq_pkg::ST_OK, (i + 1 == count));
    endfunction

    function void take_word(idq_pkg::req_t w);
      int unsigned kept;
      int unsigned n;
      logic [31:0] v;
      words_taken++;
      case (w.opcode)
        idq_pkg::OP_PUSH_FRONT, idq_pkg::OP_PUSH_BACK: begin
          if (fill >= CAP) begin
            await_word('0, idq_pkg::ST_FULL, 1'b1);
          end else begin
            if (w.opcode == idq_pkg::OP_PUSH_FRONT) begin
              head = (head + CAP - 1) % CAP;
              slot[head] = w.operand;
            end else begin
              slot[(head + fill) % CAP] = w.operand;
            end
            fill++;
            await_word('0, idq_pkg::ST_OK, 1'b1);
          end
        end
        idq_pkg::OP_POP_FRONT, idq_pkg::OP_POP_BACK: begin
          if (fill == 0) begin
            await_word('0, idq_pkg::ST_EMPTY, 1'b1);
          end else begin
            if (w.opcode == idq_pkg::OP_POP_FRONT) begin
              v = slot[head];
              head = (head + 1) % CAP;
            end else begin
              v = slot[(head + fill - 1) % CAP];
            end
            fill--;
            await_word(v, idq_pkg::ST_OK, 1'b1);
          end
        end
        idq_pkg::OP_DELETE: begin
          kept = 0;
          for (int unsigned i = 0; i < fill; i++) begin
            v = slot[(head + i) % CAP];
            if (v != w.operand) begin
              slot[(head + kept) % CAP] = v;
              kept++;
            end
          end
          fill = kept;
          await_word('0, idq_pkg::ST_OK, 1'b1);
        end
        idq_pkg::OP_CLEAR: begin
          fill = 0;
          head = 0;
          await_word('0, idq_pkg::ST_OK, 1'b1);
        end
        idq_pkg::OP_EMIT_ALL: emit_span(0, fill);
        idq_pkg::OP_EMIT_FIRST: emit_span(0, clamp_count(w.operand));
        idq_pkg::OP_EMIT_LAST: begin
          n = clamp_count(w.operand);
          emit_span(fill - n, n);
        end
        default: await_word('0, idq_pkg::ST_OK, 1'b1);
      endcase
      if (fill > peak_fill) peak_fill = fill;
    endfunction

    function void match_result(idq_pkg::res_t got);
      idq_pkg::res_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        $error("unexpected result: data %0d, status %0d, last %0d",
               got.data, got.status, got.last);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.data !== want.data) begin
        $error("data: expected %0d, got %0d", want.data, got.data);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          start;
  logic          busy;
  idq_pkg::req_t req_i;
  logic          res_valid_o;
  idq_pkg::res_t res_o;

  deque_mirror mirror;
  int unsigned cycles = 0;
  int unsigned burst_left;
  int unsigned ignored_words;
  int unsigned pick;
  int unsigned push_w;
  logic [31:0] pool [4];
  logic [31:0] val;
  logic [31:0] cnt;

  integer_deque_with_value_delete dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o === 1'b1) mirror.match_result(res_o);
  end

  task automatic issue(input logic [3:0] op, input logic [31:0] operand);
    idq_pkg::req_t w;
    int unsigned gap;
    w.opcode  = op;
    w.operand = operand;
    @(negedge clk_i);
    start = 1'b1;
    req_i = w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    mirror.take_word(w);
    if (op > idq_pkg::OP_EMIT_LAST) ignored_words++;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
      @(negedge clk_i);
      start = 1'b0;
      req_i.opcode  = 4'($urandom);
      req_i.operand = $urandom;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
    end else begin
      burst_left--;
    end
  endtask

  task automatic fill_to_full();
    while (mirror.fill < CAP)
      issue($urandom_range(0, 1) ? idq_pkg::OP_PUSH_FRONT : idq_pkg::OP_PUSH_BACK,
            $urandom_range(0, 1) ? pool[$urandom_range(0, 3)] : $urandom);
    issue(idq_pkg::OP_PUSH_BACK, $urandom);
    issue(idq_pkg::OP_PUSH_FRONT, $urandom);
    issue(idq_pkg::OP_EMIT_ALL, '0);
    issue(idq_pkg::OP_EMIT_LAST, CAP);
    issue(idq_pkg::OP_DELETE, pool[$urandom_range(0, 3)]);
  endtask

  initial begin
    mirror        = new();
    rst_ni        = 1'b0;
    start         = 1'b0;
    req_i         = '0;
    burst_left    = 0;
    ignored_words = 0;
    foreach (pool[i]) pool[i] = $urandom;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    issue(idq_pkg::OP_POP_FRONT, '0);
    issue(idq_pkg::OP_POP_BACK, '0);
    issue(idq_pkg::OP_EMIT_ALL, '0);
    issue(idq_pkg::OP_EMIT_FIRST, 32'd3);
    issue(idq_pkg::OP_EMIT_LAST, 32'd3);
    issue(idq_pkg::OP_DELETE, '0);
    issue(OP_UNUSED_HI, 32'hffff_ffff);
    issue(OP_UNUSED_LO, 32'h1234_5678);
    issue(idq_pkg::OP_PUSH_FRONT, 32'h8000_0000);
    issue(idq_pkg::OP_PUSH_BACK, 32'h7fff_ffff);
    issue(idq_pkg::OP_PUSH_FRONT, 32'hffff_ffff);
    issue(idq_pkg::OP_PUSH_BACK, '0);
    issue(idq_pkg::OP_PUSH_BACK, 32'h7fff_ffff);
    issue(idq_pkg::OP_EMIT_ALL, '0);
    issue(idq_pkg::OP_EMIT_FIRST, '0);
    issue(idq_pkg::OP_EMIT_FIRST, 32'hffff_fffb);
    issue(idq_pkg::OP_EMIT_FIRST, 32'd2);
    issue(idq_pkg::OP_EMIT_LAST, 32'd100);
    issue(idq_pkg::OP_DELETE, 32'h7fff_ffff);
    issue(idq_pkg::OP_DELETE, 32'd12345);
    issue(idq_pkg::OP_POP_BACK, '0);
    issue(idq_pkg::OP_POP_FRONT, '0);
    issue(idq_pkg::OP_EMIT_ALL, '0);
    issue(idq_pkg::OP_CLEAR, '0);
    issue(idq_pkg::OP_EMIT_ALL, '0);

    fill_to_full();
    while (mirror.words_taken < ITEMS_TARGET) begin
      if ($urandom_range(0, 49) == 0) begin
        fill_to_full();
      end else begin
        pick   = $urandom_range(0, 99);
        push_w = (mirror.fill < 16) ? 45 : 25;
        val    = ($urandom_range(0, 2) != 0) ? pool[$urandom_range(0, 3)] : $urandom;
        case ($urandom_range(0, 5))
          0:       cnt = $urandom;
          1:       cnt = mirror.fill;
          default: cnt = $urandom_range(0, 34);
        endcase
        if (pick < push_w)
          issue($urandom_range(0, 1) ? idq_pkg::OP_PUSH_FRONT : idq_pkg::OP_PUSH_BACK, val);
        else if (pick < push_w + 15)
          issue($urandom_range(0, 1) ? idq_pkg::OP_POP_FRONT : idq_pkg::OP_POP_BACK, $urandom);
        else if (pick < push_w + 23)
          issue(idq_pkg::OP_DELETE, val);
        else if (pick < push_w + 25)
          issue(idq_pkg::OP_CLEAR, $urandom);
        else if (pick < push_w + 31)
          issue(idq_pkg::OP_EMIT_ALL, $urandom);
        else if (pick < push_w + 38)
          issue(idq_pkg::OP_EMIT_FIRST, cnt);
        else if (pick < push_w + 45)
          issue(idq_pkg::OP_EMIT_LAST, cnt);
        else
          issue(4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), $urandom);
      end
    end

    @(negedge clk_i);
    start = 1'b0;
    while (mirror.awaited.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d commands (%0d with unused opcodes), checked %0d result words.",
             mirror.words_taken, ignored_words, mirror.results_seen);
    $display("Peak fill %0d of %0d; %0d full and %0d empty reports seen.",
             mirror.peak_fill, CAP, mirror.full_hits, mirror.empty_hits);
    if (mirror.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### filelist.f
src/idq_pkg.sv
src/idq_store.sv
src/integer_deque_with_value_delete.sv
verif/testbench.sv
